>>> src/kge_pkg.sv
// Package for the kinematic goal extrapolation block: item types, codes and datapath helpers.
`default_nettype none
package kge_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] accel_goal_x;
        logic signed [31:0] accel_goal_y;
        logic signed [31:0] steady_goal_x;
        logic signed [31:0] steady_goal_y;
    } out_item_t;

    // Configuration register indexes.
    localparam int unsigned CfgAddrW = 1;
    localparam logic [CfgAddrW-1:0] REG_SPEED_LIMIT = 1'd0;
    localparam logic [CfgAddrW-1:0] REG_HORIZON     = 1'd1;

    localparam logic [30:0] SpeedLimitRst = 31'd131072;
    localparam logic [30:0] HorizonRst    = 31'd65536;

    localparam logic signed [65:0] SatHi = 66'sd2147483647;
    localparam logic signed [65:0] SatLo = -66'sd2147483648;

    // State of one digit-by-digit square root lane.
    typedef struct packed {
        logic [63:0] n;
        logic [33:0] rem;
        logic [31:0] root;
    } sqst_t;

    // State of one restoring division lane with a 31-bit quotient.
    typedef struct packed {
        logic [30:0] num;
        logic [31:0] rem;
        logic [30:0] quo;
    } divst_t;

    // One result bit of floor(sqrt(n)), two radicand bits consumed.
    function automatic sqst_t sqrt_step(sqst_t s);
        sqst_t r;
        logic [33:0] part;
        logic [33:0] trial;
        part  = {s.rem[31:0], s.n[63:62]};
        trial = {s.root, 2'b01};
        r.n   = {s.n[61:0], 2'b00};
        if (part >= trial) begin
            r.rem  = part - trial;
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = part;
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    // The upper part of the dividend must already be below the divisor.
    function automatic divst_t div_init(logic [62:0] dd);
        divst_t r;
        r.rem = dd[62:31];
        r.num = dd[30:0];
        r.quo = '0;
        return r;
    endfunction

    function automatic divst_t div_step(divst_t s, logic [31:0] d);
        divst_t r;
        logic [32:0] part;
        part  = {s.rem, s.num[30]};
        r.num = {s.num[29:0], 1'b0};
        if (part >= {1'b0, d}) begin
            r.rem = 32'(part - {1'b0, d});
            r.quo = {s.quo[29:0], 1'b1};
        end else begin
            r.rem = part[31:0];
            r.quo = {s.quo[29:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(logic signed [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    function automatic logic signed [31:0] apply_sign(logic neg, logic [31:0] m);
        return neg ? signed'(~m + 32'd1) : signed'(m);
    endfunction

    // Q16.16 value placed in a Q34.32 word.
    function automatic logic signed [65:0] q_to_wide(logic signed [31:0] p);
        return {{18{p[31]}}, p, 16'h0000};
    endfunction

    // Floor of a Q.32 word to Q16.16, saturated to 32 bits.
    function automatic logic signed [31:0] sat_floor16(logic signed [65:0] x);
        logic signed [65:0] y;
        y = x >>> 16;
        if (y > SatHi) begin
            return 32'sh7FFF_FFFF;
        end else if (y < SatLo) begin
            return 32'sh8000_0000;
        end
        return y[31:0];
    endfunction

    // Right shift that brings a 48-bit magnitude below 2^31.
    function automatic logic [4:0] shift_count(logic [47:0] v);
        logic [4:0] k;
        k = 5'd0;
        for (int b = 31; b <= 47; b++) begin
            if (v[b]) begin
                k = 5'(b - 30);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

>>> src/kinematic_goal_extrapolation.sv
// Top level of the kinematic goal extrapolation block: a fully pipelined datapath.
`default_nettype none
// The block takes one agent item per cycle (position, velocity and acceleration, all
// signed Q16.16) and returns one item holding the constant-acceleration goal and the
// constant-velocity goal at the end of the configured horizon. The datapath is a
// 176-stage pipeline, and a new item can enter in every cycle unless the pipeline
// holds. Most of the depth comes from two 32-stage square root units (one bit per
// stage) and three 31-stage restoring dividers (one quotient bit per stage), used for
// the speed clamps and the acceleration time. When the result is not taken the whole
// pipeline holds, and a one-item skid buffer on the input keeps s_ready a plain
// register. Configuration is read live by the stages, so it must only be written while
// no item is in flight.
module kinematic_goal_extrapolation (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  kge_pkg::in_item_t            s_item,
    output logic                         m_valid,
    input  wire                          m_ready,
    output kge_pkg::out_item_t           m_item,
    input  wire                          cfg_wr_en,
    input  wire [kge_pkg::CfgAddrW-1:0]  cfg_addr,
    input  wire [30:0]                   cfg_wr_data
);
    import kge_pkg::*;

    // Stage positions along the pipeline.
    localparam int SQ1 = 3;
    localparam int C1  = SQ1 + 32;
    localparam int DV1 = C1 + 1;
    localparam int C2  = DV1 + 31;
    localparam int SQ2 = C2 + 7;
    localparam int C9  = SQ2 + 32;
    localparam int DV2 = C9 + 1;
    localparam int C10 = DV2 + 31;
    localparam int DV3 = C10 + 3;
    localparam int C13 = DV3 + 31;
    localparam int Lat = C13 + 4;

    // Everything one item carries; each stage updates the fields it owns.
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [63:0] tax;
        logic signed [63:0] tay;
        logic signed [63:0] tvx;
        logic signed [63:0] tvy;
        logic signed [65:0] prod0;
        logic signed [65:0] prod1;
        logic signed [65:0] prod2;
        logic signed [65:0] prod3;
        logic signed [31:0] stx;
        logic signed [31:0] sty;
        sqst_t              sa;
        sqst_t              sb;
        logic [31:0]        sp;
        logic [31:0]        am;
        logic [31:0]        gs;
        logic [62:0]        ua;
        logic [62:0]        ub;
        divst_t             da;
        divst_t             db;
        logic               clamp;
        logic               kpos;
        logic               neg;
        logic               clamp2;
        logic               big;
        logic               zero;
        logic signed [64:0] fxs;
        logic signed [64:0] fys;
        logic [47:0]        fmx;
        logic [47:0]        fmy;
        logic               fsx;
        logic               fsy;
        logic [4:0]         kshift;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic [31:0]        fs;
        logic [30:0]        diff;
        logic [30:0]        ta;
        logic [30:0]        tu;
        logic signed [32:0] svx;
        logic signed [32:0] svy;
        logic signed [65:0] accx;
        logic signed [65:0] accy;
        logic signed [31:0] agx;
        logic signed [31:0] agy;
    } pipe_t;

    logic [30:0] speed_limit_reg, speed_limit_next;
    logic [30:0] horizon_reg, horizon_next;

    in_item_t    skid_reg;
    logic        skid_valid_reg, skid_valid_next;
    in_item_t    feed_item;
    logic        feed_valid;
    logic        pipe_en;
    logic        s_accept;

    logic [Lat-1:0] vld_reg, vld_next;
    pipe_t          pipe_reg  [Lat];
    pipe_t          pipe_next [Lat];
    pipe_t          stage_in  [Lat];

    // Configuration registers.
    always_comb begin
        speed_limit_next = speed_limit_reg;
        horizon_next     = horizon_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SPEED_LIMIT: speed_limit_next = cfg_wr_data;
                REG_HORIZON:     horizon_next     = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit_reg <= SpeedLimitRst;
            horizon_reg     <= HorizonRst;
        end else begin
            speed_limit_reg <= speed_limit_next;
            horizon_reg     <= horizon_next;
        end
    end

    // The pipeline moves as a whole whenever the output stage is free or being read.
    // An item arriving during a stall waits in the skid buffer.
    assign pipe_en    = !vld_reg[Lat-1] || m_ready;
    assign s_ready    = !skid_valid_reg;
    assign s_accept   = s_valid && s_ready;
    assign feed_item  = skid_valid_reg ? skid_reg : s_item;
    assign feed_valid = skid_valid_reg || s_accept;

    always_comb begin
        if (skid_valid_reg) begin
            skid_valid_next = !pipe_en;
        end else begin
            skid_valid_next = s_accept && !pipe_en;
        end
    end

    assign vld_next = {vld_reg[Lat-2:0], feed_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            vld_reg        <= '0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            if (pipe_en) begin
                vld_reg <= vld_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && !pipe_en) begin
            skid_reg <= s_item;
        end
        if (pipe_en) begin
            pipe_reg <= pipe_next;
        end
    end

    always_comb begin
        stage_in[0]    = '0;
        stage_in[0].px = feed_item.pos_x;
        stage_in[0].py = feed_item.pos_y;
        stage_in[0].vx = feed_item.vel_x;
        stage_in[0].vy = feed_item.vel_y;
        stage_in[0].ax = feed_item.acc_x;
        stage_in[0].ay = feed_item.acc_y;
    end

    for (genvar i = 0; i < Lat; i++) begin : g_stage
        if (i > 0) begin : g_link
            assign stage_in[i] = pipe_reg[i-1];
        end

        always_comb begin
            pipe_t              w;
            logic signed [31:0] t_s;
            logic [64:0]        magx;
            logic [64:0]        magy;
            logic signed [65:0] dot;
            logic signed [65:0] sumsq;
            logic signed [32:0] dtmp;
            w     = stage_in[i];
            t_s   = signed'({1'b0, horizon_reg});
            magx  = '0;
            magy  = '0;
            dot   = '0;
            sumsq = '0;
            dtmp  = '0;
            if (i == 1) begin
                // Squares for both magnitudes and the horizon products.
                w.prod0 = 66'(64'(w.vx) * 64'(w.vx));
                w.prod1 = 66'(64'(w.vy) * 64'(w.vy));
                w.prod2 = 66'(64'(w.ax) * 64'(w.ax));
                w.prod3 = 66'(64'(w.ay) * 64'(w.ay));
                w.tax   = 64'(t_s) * 64'(w.ax);
                w.tay   = 64'(t_s) * 64'(w.ay);
            end else if (i == 2) begin
                sumsq  = w.prod0 + w.prod1;
                w.sa.n = sumsq[63:0];
                w.sa.rem  = '0;
                w.sa.root = '0;
                sumsq  = w.prod2 + w.prod3;
                w.sb.n = sumsq[63:0];
                w.sb.rem  = '0;
                w.sb.root = '0;
            end else if (i >= SQ1 && i < SQ1 + 32) begin
                w.sa = sqrt_step(w.sa);
                w.sb = sqrt_step(w.sb);
            end else if (i == C1) begin
                w.sp    = w.sa.root;
                w.am    = w.sb.root;
                w.clamp = w.sa.root > {1'b0, speed_limit_reg};
                w.ua    = 63'(abs32(w.vx)) * 63'(speed_limit_reg);
                w.ub    = 63'(abs32(w.vy)) * 63'(speed_limit_reg);
            end else if (i >= DV1 && i < DV1 + 31) begin
                if (i == DV1) begin
                    w.da = div_step(div_init(w.ua), w.sp);
                    w.db = div_step(div_init(w.ub), w.sp);
                end else begin
                    w.da = div_step(w.da, w.sp);
                    w.db = div_step(w.db, w.sp);
                end
            end else if (i == C2) begin
                if (w.clamp) begin
                    w.vx = apply_sign(w.vx[31], {1'b0, w.da.quo});
                    w.vy = apply_sign(w.vy[31], {1'b0, w.db.quo});
                    w.sp = 32'(speed_limit_reg);
                end
            end else if (i == C2 + 1) begin
                // The steady goal moves at the clamped velocity.
                w.fxs = {{17{w.vx[31]}}, w.vx, 16'h0000} + 65'(w.tax);
                w.fys = {{17{w.vy[31]}}, w.vy, 16'h0000} + 65'(w.tay);
                w.tvx = 64'(t_s) * 64'(w.vx);
                w.tvy = 64'(t_s) * 64'(w.vy);
            end else if (i == C2 + 2) begin
                // Final velocity held as sign and magnitude, truncated toward zero.
                magx  = w.fxs[64] ? 65'(-w.fxs) : 65'(w.fxs);
                magy  = w.fys[64] ? 65'(-w.fys) : 65'(w.fys);
                w.fsx = w.fxs[64];
                w.fsy = w.fys[64];
                w.fmx = magx[63:16];
                w.fmy = magy[63:16];
                w.stx = sat_floor16(66'(w.tvx) + q_to_wide(w.px));
                w.sty = sat_floor16(66'(w.tvy) + q_to_wide(w.py));
            end else if (i == C2 + 3) begin
                w.kshift = shift_count(w.fmx | w.fmy);
            end else if (i == C2 + 4) begin
                w.gx   = apply_sign(w.fsx, 32'(w.fmx >> w.kshift));
                w.gy   = apply_sign(w.fsy, 32'(w.fmy >> w.kshift));
                w.kpos = w.kshift != 5'd0;
            end else if (i == C2 + 5) begin
                w.prod0 = 66'(64'(w.gx) * 64'(w.vx));
                w.prod1 = 66'(64'(w.gy) * 64'(w.vy));
                w.prod2 = 66'(64'(w.gx) * 64'(w.gx));
                w.prod3 = 66'(64'(w.gy) * 64'(w.gy));
            end else if (i == C2 + 6) begin
                dot       = w.prod0 + w.prod1;
                w.neg     = dot[65];
                sumsq     = w.prod2 + w.prod3;
                w.sa.n    = sumsq[63:0];
                w.sa.rem  = '0;
                w.sa.root = '0;
            end else if (i >= SQ2 && i < SQ2 + 32) begin
                w.sa = sqrt_step(w.sa);
            end else if (i == C9) begin
                w.gs     = w.sa.root;
                w.clamp2 = w.kpos || (w.sa.root > {1'b0, speed_limit_reg});
                w.ua     = 63'(abs32(w.gx)) * 63'(speed_limit_reg);
                w.ub     = 63'(abs32(w.gy)) * 63'(speed_limit_reg);
            end else if (i >= DV2 && i < DV2 + 31) begin
                if (i == DV2) begin
                    w.da = div_step(div_init(w.ua), w.gs);
                    w.db = div_step(div_init(w.ub), w.gs);
                end else begin
                    w.da = div_step(w.da, w.gs);
                    w.db = div_step(w.db, w.gs);
                end
            end else if (i == C10) begin
                // A reversal becomes a stop; otherwise clamp the final speed.
                if (w.neg) begin
                    w.fx = '0;
                    w.fy = '0;
                    w.fs = '0;
                end else if (w.clamp2) begin
                    w.fx = apply_sign(w.gx[31], {1'b0, w.da.quo});
                    w.fy = apply_sign(w.gy[31], {1'b0, w.db.quo});
                    w.fs = 32'(speed_limit_reg);
                end else begin
                    w.fx = w.gx;
                    w.fy = w.gy;
                    w.fs = w.gs;
                end
            end else if (i == C10 + 1) begin
                dtmp   = signed'({1'b0, w.fs}) - signed'({1'b0, w.sp});
                dtmp   = dtmp[32] ? -dtmp : dtmp;
                w.diff = dtmp[30:0];
            end else if (i == C10 + 2) begin
                // A quotient of 2^31 or more is beyond any horizon.
                w.ua   = 63'({w.diff, 16'h0000});
                w.big  = {16'h0000, w.diff[30:15]} >= w.am;
                w.zero = w.am == 32'd0;
            end else if (i >= DV3 && i < DV3 + 31) begin
                if (i == DV3) begin
                    w.da = div_step(div_init(w.ua), w.am);
                end else begin
                    w.da = div_step(w.da, w.am);
                end
            end else if (i == C13) begin
                if (w.zero) begin
                    w.ta = '0;
                end else if (w.big || (w.da.quo > horizon_reg)) begin
                    w.ta = horizon_reg;
                end else begin
                    w.ta = w.da.quo;
                end
                w.tu  = horizon_reg - w.ta;
                w.svx = 33'(w.vx) + 33'(w.fx);
                w.svy = 33'(w.vy) + 33'(w.fy);
            end else if (i == C13 + 1) begin
                w.prod0 = 66'(signed'({1'b0, w.ta})) * 66'(w.svx);
                w.prod1 = 66'(signed'({1'b0, w.tu})) * 66'(w.fx);
                w.prod2 = 66'(signed'({1'b0, w.ta})) * 66'(w.svy);
                w.prod3 = 66'(signed'({1'b0, w.tu})) * 66'(w.fy);
            end else if (i == C13 + 2) begin
                w.accx = (w.prod0 >>> 1) + w.prod1 + q_to_wide(w.px);
                w.accy = (w.prod2 >>> 1) + w.prod3 + q_to_wide(w.py);
            end else if (i == C13 + 3) begin
                w.agx = sat_floor16(w.accx);
                w.agy = sat_floor16(w.accy);
            end
            pipe_next[i] = w;
        end
    end

    // The last stage is the output register.
    assign m_valid = vld_reg[Lat-1];
    always_comb begin
        m_item.accel_goal_x  = pipe_reg[Lat-1].agx;
        m_item.accel_goal_y  = pipe_reg[Lat-1].agy;
        m_item.steady_goal_x = pipe_reg[Lat-1].stx;
        m_item.steady_goal_y = pipe_reg[Lat-1].sty;
    end

endmodule
`default_nettype wire
